// File: hdl/qrv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared constants and register codes for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qrv_pkg;

  // default field widths
  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;

  // configuration register index width
  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } cfg_reg_e;

  // number of register stages in the datapath
  localparam int unsigned NUM_STAGES = 5;

endpackage

// File: hdl/quaternion_rotate_vector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_top
// Rotates a stream of 3D vectors by the quaternion held in configuration.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid / tready           tdata: vec_x, vec_y, vec_z
//  m_axis    out        tvalid / tready           tdata: rot_x, rot_y, rot_z
//                                                 tuser: saturated
//  cfg       in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
//  One vector per cycle while m_axis accepts; from input to m_axis, each step
//  is registered: first products, p sums, second products, rounded sums,
//  shift and saturate. Each stage holds its own valid bit and loads whenever
//  it is empty or the stage after it moves, so bubbles close up under a stall.
//  Reset clears the valid bits and loads the identity quaternion.
// ----------------------------------------------------------------------------
module quaternion_rotate_vector_top #(
  parameter int unsigned DATA_WIDTH = qrv_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = qrv_pkg::FRAC_BITS_DEF,
  parameter int unsigned TDATA_W    = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [qrv_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]         cfg_data_i,
  // input vectors
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [TDATA_W-1:0]            s_axis_tdata_i,  // vec_x, vec_y, vec_z, zero pad
  // rotated vectors
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [TDATA_W-1:0]            m_axis_tdata_o,  // rot_x, rot_y, rot_z, zero pad
  output logic                          m_axis_tuser_o   // saturated
);
  import qrv_pkg::*;

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned NS    = NUM_STAGES;
  localparam int unsigned M1W   = 2 * W;        // q * v product
  localparam int unsigned PW    = 2 * W + 2;    // sum of three products
  localparam int unsigned M2W   = PW + W;       // p * q product
  localparam int unsigned SW    = PW + W + 3;   // sum of four plus rounding
  localparam int unsigned SHIFT = 2 * FRAC_BITS;
  localparam int unsigned PADW  = TDATA_W - 3 * W;

  localparam logic signed [SW-1:0] RND     = SW'(1) << (SHIFT - 1);
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic        [W-1:0]  QUAT_ONE = W'(1) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [W-1:0] quat_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[0] <= QUAT_ONE;
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_QUAT_W: quat_q[0] <= cfg_data_i;
        REG_QUAT_X: quat_q[1] <= cfg_data_i;
        REG_QUAT_Y: quat_q[2] <= cfg_data_i;
        REG_QUAT_Z: quat_q[3] <= cfg_data_i;
        default:    quat_q[0] <= quat_q[0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage control: a stage loads when empty or when the next one moves
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld_q, vld_d;
  logic [NS:0]   en;

  assign en[NS] = m_axis_tready_i;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) vld_d[0] = s_axis_tvalid_i;
    for (int k = 1; k < NS; k++) begin
      if (en[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = vld_q[NS-1];

  // --------------------------------------------------------------------------
  // stage 1: q * v products
  // --------------------------------------------------------------------------
  logic signed [W-1:0]   vec_x, vec_y, vec_z;
  logic signed [M1W-1:0] m1_q [12];
  logic signed [M1W-1:0] m1_d [12];

  assign vec_x = s_axis_tdata_i[W-1:0];
  assign vec_y = s_axis_tdata_i[2*W-1:W];
  assign vec_z = s_axis_tdata_i[3*W-1:2*W];

  always_comb begin
    // x part terms
    m1_d[0]  = quat_q[0] * vec_x;
    m1_d[1]  = quat_q[2] * vec_z;
    m1_d[2]  = quat_q[3] * vec_y;
    // y part terms
    m1_d[3]  = quat_q[0] * vec_y;
    m1_d[4]  = quat_q[1] * vec_z;
    m1_d[5]  = quat_q[3] * vec_x;
    // z part terms
    m1_d[6]  = quat_q[0] * vec_z;
    m1_d[7]  = quat_q[1] * vec_y;
    m1_d[8]  = quat_q[2] * vec_x;
    // scalar part terms
    m1_d[9]  = quat_q[1] * vec_x;
    m1_d[10] = quat_q[2] * vec_y;
    m1_d[11] = quat_q[3] * vec_z;
  end

  // --------------------------------------------------------------------------
  // stage 2: p = q * (0, v), index 0 is the scalar part
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] p_q [4];
  logic signed [PW-1:0] p_d [4];

  always_comb begin
    p_d[0] = -PW'(m1_q[9]) - PW'(m1_q[10]) - PW'(m1_q[11]);
    p_d[1] =  PW'(m1_q[0]) + PW'(m1_q[1])  - PW'(m1_q[2]);
    p_d[2] =  PW'(m1_q[3]) - PW'(m1_q[4])  + PW'(m1_q[5]);
    p_d[3] =  PW'(m1_q[6]) + PW'(m1_q[7])  - PW'(m1_q[8]);
  end

  // --------------------------------------------------------------------------
  // stage 3: p * conj(q) products
  // --------------------------------------------------------------------------
  logic signed [M2W-1:0] m2_q [12];
  logic signed [M2W-1:0] m2_d [12];

  always_comb begin
    m2_d[0]  = p_q[0] * quat_q[1];
    m2_d[1]  = p_q[1] * quat_q[0];
    m2_d[2]  = p_q[2] * quat_q[3];
    m2_d[3]  = p_q[3] * quat_q[2];
    m2_d[4]  = p_q[0] * quat_q[2];
    m2_d[5]  = p_q[1] * quat_q[3];
    m2_d[6]  = p_q[2] * quat_q[0];
    m2_d[7]  = p_q[3] * quat_q[1];
    m2_d[8]  = p_q[0] * quat_q[3];
    m2_d[9]  = p_q[1] * quat_q[2];
    m2_d[10] = p_q[2] * quat_q[1];
    m2_d[11] = p_q[3] * quat_q[0];
  end

  // --------------------------------------------------------------------------
  // stage 4: vector part sums with the half-up rounding offset
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] acc_q [3];
  logic signed [SW-1:0] acc_d [3];

  always_comb begin
    acc_d[0] = RND - SW'(m2_q[0]) + SW'(m2_q[1])  - SW'(m2_q[2])  + SW'(m2_q[3]);
    acc_d[1] = RND - SW'(m2_q[4]) + SW'(m2_q[5])  + SW'(m2_q[6])  - SW'(m2_q[7]);
    acc_d[2] = RND - SW'(m2_q[8]) - SW'(m2_q[9])  + SW'(m2_q[10]) + SW'(m2_q[11]);
  end

  // --------------------------------------------------------------------------
  // stage 5: shift, clamp and flag
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] shr   [3];
  logic        [W-1:0]  rot_d [3];
  logic        [W-1:0]  rot_q [3];
  logic [2:0]           clip;
  logic                 sat_d, sat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shr[i]  = acc_q[i] >>> SHIFT;
      clip[i] = 1'b0;
      if (shr[i] > SAT_MAX) begin
        rot_d[i] = SAT_MAX[W-1:0];
        clip[i]  = 1'b1;
      end else if (shr[i] < SAT_MIN) begin
        rot_d[i] = SAT_MIN[W-1:0];
        clip[i]  = 1'b1;
      end else begin
        rot_d[i] = shr[i][W-1:0];
      end
    end
    sat_d = |clip;
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en[0]) m1_q  <= m1_d;
    if (en[1]) p_q   <= p_d;
    if (en[2]) m2_q  <= m2_d;
    if (en[3]) acc_q <= acc_d;
    if (en[4]) begin
      rot_q <= rot_d;
      sat_q <= sat_d;
    end
  end

  if (PADW > 0) begin : g_pad
    assign m_axis_tdata_o = {{PADW{1'b0}}, rot_q[2], rot_q[1], rot_q[0]};
  end else begin : g_nopad
    assign m_axis_tdata_o = {rot_q[2], rot_q[1], rot_q[0]};
  end
  assign m_axis_tuser_o = sat_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the flag is only set when some component sits on a clamp bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (rot_q[0] == SAT_MAX[W-1:0] || rot_q[0] == SAT_MIN[W-1:0] ||
       rot_q[1] == SAT_MAX[W-1:0] || rot_q[1] == SAT_MIN[W-1:0] ||
       rot_q[2] == SAT_MAX[W-1:0] || rot_q[2] == SAT_MIN[W-1:0]))
    else $error("saturated flag without a clamped component");

  // input is refused only when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&vld_q))
    else $error("input stalled while the pipeline has a bubble");

  // the first stage fills only through an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[0]) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("first stage became valid without a transfer");

  // a stalled result is not dropped by the stage behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("stalled result lost");

endmodule

// File: dv/qrv_rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrv_rotation_checker
// Watches the configuration port and both streams of the quaternion vector
// rotator. It keeps its own copy of the quaternion and predicts the rotated
// vector for every input transfer. Each output transfer is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module qrv_rotation_checker #(
  parameter int unsigned DW      = qrv_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC    = qrv_pkg::FRAC_BITS_DEF,
  parameter int unsigned TDATA_W = ((3 * DW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qrv_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [DW-1:0]                 cfg_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [TDATA_W-1:0]            s_tdata_i,  // vec_x, vec_y, vec_z, zero pad
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [TDATA_W-1:0]            m_tdata_i,  // rot_x, rot_y, rot_z, zero pad
  input  logic                          m_tuser_i,  // saturated
  output int                            errors_o,
  output int                            pending_o
);
  import qrv_pkg::*;

  typedef struct packed {
    logic [DW-1:0] w;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] z;
  } rotated_t;

  quat_t    quat_shadow;
  rotated_t expected_rot_q[$];
  int       error_count   = 0;
  int       vectors_owed  = 0;
  int       results_seen  = 0;

  assign errors_o  = error_count;
  assign pending_o = vectors_owed;

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      flag_error($sformatf("result %0d %s: expected %0d, got %0d",
                           results_seen, name, want, got));
    end
  endtask

  // vector part of q * (0,v) * conj(q), rounded half up and clamped
  function automatic rotated_t rotate_by_quat(input quat_t q, input logic [TDATA_W-1:0] data);
    longint   qw, qx, qy, qz, vx, vy, vz;
    longint   tw, tx, ty, tz;
    longint   acc [3];
    longint   r, lim_hi, lim_lo;
    logic [DW-1:0] comp [3];
    rotated_t res;
    qw = $signed(q.w);
    qx = $signed(q.x);
    qy = $signed(q.y);
    qz = $signed(q.z);
    vx = $signed(data[DW-1:0]);
    vy = $signed(data[2*DW-1:DW]);
    vz = $signed(data[3*DW-1:2*DW]);
    // first product, scaled by 2^FRAC
    tw = -qx * vx - qy * vy - qz * vz;
    tx = qw * vx + qy * vz - qz * vy;
    ty = qw * vy - qx * vz + qz * vx;
    tz = qw * vz + qx * vy - qy * vx;
    // times conj(q), scaled by 2^(2*FRAC)
    acc[0] = -tw * qx + tx * qw - ty * qz + tz * qy;
    acc[1] = -tw * qy + tx * qz + ty * qw - tz * qx;
    acc[2] = -tw * qz - tx * qy + ty * qx + tz * qw;
    lim_hi = (64'sd1 <<< (DW - 1)) - 1;
    lim_lo = -(64'sd1 <<< (DW - 1));
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = (acc[i] + (64'sd1 <<< (2 * FRAC - 1))) >>> (2 * FRAC);
      if (r > lim_hi) begin
        r = lim_hi;
        res.sat = 1'b1;
      end else if (r < lim_lo) begin
        r = lim_lo;
        res.sat = 1'b1;
      end
      comp[i] = r[DW-1:0];
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rotated_t got;
    rotated_t want;
    if (!rst_ni) begin
      expected_rot_q.delete();
      vectors_owed = 0;
      quat_shadow  = '{w: DW'(1 << FRAC), x: '0, y: '0, z: '0};
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = '{sat: m_tuser_i, x: m_tdata_i[DW-1:0], y: m_tdata_i[2*DW-1:DW],
                z: m_tdata_i[3*DW-1:2*DW]};
        if (expected_rot_q.size() == 0) begin
          flag_error($sformatf("result %0d with no vector outstanding: %0d %0d %0d sat %0b",
                               results_seen, $signed(got.x), $signed(got.y),
                               $signed(got.z), got.sat));
        end else begin
          want = expected_rot_q.pop_front();
          vectors_owed--;
          check_field("rot_x", $signed(want.x), $signed(got.x));
          check_field("rot_y", $signed(want.y), $signed(got.y));
          check_field("rot_z", $signed(want.z), $signed(got.z));
          check_field("saturated", want.sat, got.sat);
        end
        results_seen++;
      end
      // predict with the quaternion in force before any write at this edge
      if (s_tvalid_i && s_tready_i) begin
        expected_rot_q.push_back(rotate_by_quat(quat_shadow, s_tdata_i));
        vectors_owed++;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_QUAT_W: quat_shadow.w = cfg_data_i;
          REG_QUAT_X: quat_shadow.x = cfg_data_i;
          REG_QUAT_Y: quat_shadow.y = cfg_data_i;
          REG_QUAT_Z: quat_shadow.z = cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the quaternion vector rotator: directed vectors for the
// identity, rounding ties, saturation and extreme quaternions, then random
// vectors under a series of random quaternions, with random gaps and
// back-pressure on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import qrv_pkg::*;

  localparam int unsigned DW        = DATA_WIDTH_DEF;
  localparam int unsigned FRAC      = FRAC_BITS_DEF;
  localparam int unsigned TDATA_W   = ((3 * DW + 7) / 8) * 8;
  localparam int          LONG_HOLD = 150;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               cfg_we   = 1'b0;
  cfg_reg_e           cfg_idx  = REG_QUAT_W;
  logic [DW-1:0]      cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;

  int chk_errors;
  int chk_pending;
  int items_sent  = 0;
  bit burst_mode  = 1'b0;
  bit held_off    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_rotate_vector_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  qrv_rotation_checker i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .s_tvalid_i(s_tvalid),
    .s_tready_i(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_i (m_tdata),
    .m_tuser_i (m_tuser),
    .errors_o  (chk_errors),
    .pending_o (chk_pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int rand_component();
    int r;
    int corner [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    r = $urandom_range(0, 99);
    if (r < 65) return int'($urandom_range(0, 65535)) - 32768;
    if (r < 85) return int'($urandom_range(0, 512)) - 256;
    return corner[$urandom_range(0, 6)];
  endfunction

  // one vector transfer, after a random gap
  task automatic send_vec(input int x, input int y, input int z);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'({z[DW-1:0], y[DW-1:0], x[DW-1:0]});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // waits until every result is out, then writes all four registers
  task automatic load_quat(input int w, input int x, input int y, input int z);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_QUAT_W;
    cfg_data <= w[DW-1:0];
    @(posedge clk);
    cfg_idx  <= REG_QUAT_X;
    cfg_data <= x[DW-1:0];
    @(posedge clk);
    cfg_idx  <= REG_QUAT_Y;
    cfg_data <= y[DW-1:0];
    @(posedge clk);
    cfg_idx  <= REG_QUAT_Z;
    cfg_data <= z[DW-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // kind 0: unit rotation, 1: any 16-bit values, 2: small (shrinks the vector)
  task automatic random_quat(input int kind, output int w, output int x,
                             output int y, output int z);
    real a, b, c, d, n;
    a = $urandom_range(0, 32768) - 16384.0;
    b = $urandom_range(0, 32768) - 16384.0;
    c = $urandom_range(0, 32768) - 16384.0;
    d = $urandom_range(0, 32768) - 16384.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (kind == 0 && n > 1.0) begin
      w = $rtoi(a * (1 << FRAC) / n);
      x = $rtoi(b * (1 << FRAC) / n);
      y = $rtoi(c * (1 << FRAC) / n);
      z = $rtoi(d * (1 << FRAC) / n);
    end else if (kind == 2) begin
      w = int'($urandom_range(0, 8192)) - 4096;
      x = int'($urandom_range(0, 8192)) - 4096;
      y = int'($urandom_range(0, 8192)) - 4096;
      z = int'($urandom_range(0, 8192)) - 4096;
    end else begin
      w = int'($urandom_range(0, 65535)) - 32768;
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
      z = int'($urandom_range(0, 65535)) - 32768;
    end
  endtask

  // output side back-pressure
  initial begin
    int r;
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && items_sent >= 600 && s_tvalid) begin
        // long stall so the pipeline fills and the input side stalls
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_tready <= 1'b1;
          n = $urandom_range(1, 12);
        end else if (r < 62) begin
          m_tready <= 1'b1;
          n = $urandom_range(40, 120);
        end else if (r < 92) begin
          m_tready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          m_tready <= 1'b0;
          n = $urandom_range(8, 30);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int qw, qx, qy, qz;
    int n_vecs;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity quaternion from reset
    send_vec(0, 0, 0);
    send_vec(32767, -32768, 1);
    send_vec(-32768, 32767, -1);
    send_vec(21845, -21846, 0);
    send_vec(-21846, 21845, -32768);

    // scale by one quarter: exact halves round toward plus infinity
    load_quat(8192, 0, 0, 0);
    send_vec(2, -2, 6);
    send_vec(-6, 10, -10);
    send_vec(3, -3, 1);

    // extreme quaternions, mostly clamping
    load_quat(-32768, -32768, -32768, -32768);
    send_vec(32767, -32768, 0);
    send_vec(1, 0, 0);
    send_vec(-1, 1, -1);
    load_quat(32767, 32767, 32767, 32767);
    send_vec(-32768, -32768, -32768);
    send_vec(0, 1, 0);
    load_quat(32767, -32768, 32767, -32768);
    send_vec(1, -1, 1);
    send_vec(1000, 0, -1000);

    // quarter turn about z
    load_quat(11585, 0, 0, 11585);
    send_vec(1000, 0, 0);
    send_vec(0, 1000, 0);
    send_vec(0, 0, -1000);

    load_quat(0, 0, 0, 0);
    send_vec(32767, 32767, 32767);

    for (int p = 0; p < 11; p++) begin
      random_quat(p % 3, qw, qx, qy, qz);
      load_quat(qw, qx, qy, qz);
      burst_mode = ($urandom_range(0, 3) == 0);
      n_vecs = $urandom_range(120, 180);
      repeat (n_vecs) send_vec(rand_component(), rand_component(), rand_component());
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    repeat (4 * NUM_STAGES) @(posedge clk);
    if (chk_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/qrv_pkg.sv
hdl/quaternion_rotate_vector_top.sv
dv/qrv_rotation_checker.sv
dv/tb_top.sv
